>>> src/irl_pkg.sv
// shared types and constants for the ipv4 route lookup block
`timescale 1ns / 1ps
package irl_pkg;

	localparam int unsigned TABLE_ENTRIES = 16;
	localparam int unsigned IFACE_COUNT = 16;

	localparam int OP_W = 2;
	localparam int IDX_W = 4;
	localparam int ADDR_W = 32;
	localparam int IFACE_W = 4;
	localparam int TTL_W = 8;
	localparam int VERDICT_W = 3;

	localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OP_W-1:0] OP_FORWARD = 2'd1;
	localparam logic [OP_W-1:0] OP_SEND = 2'd2;

	localparam logic [VERDICT_W-1:0] VERDICT_FOUND = 3'd0;
	localparam logic [VERDICT_W-1:0] VERDICT_TTL_EXPIRED = 3'd1;
	localparam logic [VERDICT_W-1:0] VERDICT_NO_ROUTE_ICMP = 3'd2;
	localparam logic [VERDICT_W-1:0] VERDICT_NO_ROUTE_DROP = 3'd3;
	localparam logic [VERDICT_W-1:0] VERDICT_WRITTEN = 3'd4;

	localparam logic [TTL_W-1:0] TTL_LIMIT = 8'd1;

	localparam int S_DATA_W = 152;
	localparam int M_DATA_W = 48;

	// input tdata layout, lowest field last
	typedef struct packed {
		logic [6:0]         pad;
		logic [TTL_W-1:0]   ttl_in;
		logic [ADDR_W-1:0]  dst_addr;
		logic [IFACE_W-1:0] entry_iface;
		logic [ADDR_W-1:0]  entry_gateway;
		logic [ADDR_W-1:0]  entry_mask;
		logic [ADDR_W-1:0]  entry_dest;
		logic               entry_valid;
		logic [IDX_W-1:0]   entry_index;
	} s_data_t;

	// output tdata layout, lowest field last
	typedef struct packed {
		logic [3:0]         pad;
		logic [TTL_W-1:0]   ttl_out;
		logic [IFACE_W-1:0] out_iface;
		logic [ADDR_W-1:0]  hop_addr;
	} m_data_t;

	// transaction travelling down the cell row, with the best match so far
	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [IDX_W-1:0]   entry_index;
		logic               entry_valid;
		logic [ADDR_W-1:0]  entry_dest;
		logic [ADDR_W-1:0]  entry_mask;
		logic [ADDR_W-1:0]  entry_gateway;
		logic [IFACE_W-1:0] entry_iface;
		logic [ADDR_W-1:0]  dst_addr;
		logic [TTL_W-1:0]   ttl;
		logic               hit;
		logic [ADDR_W-1:0]  best_mask;
		logic [ADDR_W-1:0]  best_gateway;
		logic [IFACE_W-1:0] best_iface;
	} tok_t;

endpackage

>>> src/irl_cell.sv
// one route table slot: stores its entry and updates the passing transaction
`timescale 1ns / 1ps
module irl_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic          in_valid,
	input  irl_pkg::tok_t in_tok,
	input  logic          slot_sel,
	output logic          out_valid,
	output irl_pkg::tok_t out_tok
);
	import irl_pkg::*;

	logic               route_valid_q;
	logic [ADDR_W-1:0]  route_dest_q;
	logic [ADDR_W-1:0]  route_mask_q;
	logic [ADDR_W-1:0]  route_gateway_q;
	logic [IFACE_W-1:0] route_iface_q;
	logic               out_valid_q;
	tok_t               out_tok_q;
	logic               match;
	logic               better;
	tok_t               nxt_tok;

	assign match = route_valid_q &&
		((in_tok.dst_addr & route_mask_q) == (route_dest_q & route_mask_q));
	assign better = match && (!in_tok.hit || (route_mask_q > in_tok.best_mask));

	always_comb begin
		nxt_tok = in_tok;
		if (better) begin
			nxt_tok.hit = 1'b1;
			nxt_tok.best_mask = route_mask_q;
			nxt_tok.best_gateway = route_gateway_q;
			nxt_tok.best_iface = route_iface_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			route_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= in_valid;
			if (in_valid && slot_sel) begin
				route_valid_q <= in_tok.entry_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_tok_q <= nxt_tok;
			if (in_valid && slot_sel) begin
				route_dest_q <= in_tok.entry_dest;
				route_mask_q <= in_tok.entry_mask;
				route_gateway_q <= in_tok.entry_gateway;
				route_iface_q <= in_tok.entry_iface;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_tok = out_tok_q;

endmodule

>>> src/ipv4_route_lookup_lpm_top.sv
// top level: row of route slot cells, transaction control and output register
// the input is held not ready from an accepted operation until its result enters the
// output register, so one transaction walks the cell row at a time; a stalled output
// holds the row until taken
// operation 3 is consumed without entering the row and gives no result
// reset clears all slot valid flags, the row and the output valid; slot data stays undefined
`timescale 1ns / 1ps
module ipv4_route_lookup_lpm_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// entry_index, entry_valid, entry_dest, entry_mask, entry_gateway, entry_iface,
	// dst_addr, ttl_in
	input  logic [irl_pkg::S_DATA_W-1:0]   s_axis_tdata,
	// operation
	input  logic [irl_pkg::OP_W-1:0]       s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// hop_addr, out_iface, ttl_out
	output logic [irl_pkg::M_DATA_W-1:0]   m_axis_tdata,
	// verdict
	output logic [irl_pkg::VERDICT_W-1:0]  m_axis_tuser
);
	import irl_pkg::*;

	s_data_t                s_data;
	logic                   accept;
	logic                   start;
	logic                   adv;
	logic                   busy_q;
	logic                   m_valid_q;
	m_data_t                m_data_q;
	logic [VERDICT_W-1:0]   verdict_q;
	logic                   chain_valid [TABLE_ENTRIES+1];
	tok_t                   chain_tok [TABLE_ENTRIES+1];
	logic                   slot_sel [TABLE_ENTRIES];
	tok_t                   head_tok;
	tok_t                   last_tok;
	logic                   last_valid;
	m_data_t                res_data;
	logic [VERDICT_W-1:0]   res_verdict;

	assign s_data = s_data_t'(s_axis_tdata);
	assign s_axis_tready = !busy_q;
	assign accept = s_axis_tvalid && s_axis_tready;
	assign start = accept && (s_axis_tuser == OP_WRITE || s_axis_tuser == OP_FORWARD ||
		s_axis_tuser == OP_SEND);

	assign last_valid = chain_valid[TABLE_ENTRIES];
	assign last_tok = chain_tok[TABLE_ENTRIES];
	assign adv = !(last_valid && m_valid_q && !m_axis_tready);

	always_comb begin
		head_tok.op = s_axis_tuser;
		head_tok.entry_index = s_data.entry_index;
		head_tok.entry_valid = s_data.entry_valid;
		head_tok.entry_dest = s_data.entry_dest;
		head_tok.entry_mask = s_data.entry_mask;
		head_tok.entry_gateway = s_data.entry_gateway;
		head_tok.entry_iface = s_data.entry_iface;
		head_tok.dst_addr = s_data.dst_addr;
		head_tok.ttl = s_data.ttl_in;
		head_tok.hit = 1'b0;
		head_tok.best_mask = '0;
		head_tok.best_gateway = '0;
		head_tok.best_iface = '0;
	end

	assign chain_valid[0] = start;
	assign chain_tok[0] = head_tok;

	for (genvar gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
		assign slot_sel[gi] = (chain_tok[gi].op == OP_WRITE) &&
			(32'(chain_tok[gi].entry_index) == gi) &&
			(32'(chain_tok[gi].entry_iface) < IFACE_COUNT);

		irl_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.in_valid  (chain_valid[gi]),
			.in_tok    (chain_tok[gi]),
			.slot_sel  (slot_sel[gi]),
			.out_valid (chain_valid[gi+1]),
			.out_tok   (chain_tok[gi+1])
		);
	end

	always_comb begin
		res_data = '0;
		res_verdict = VERDICT_WRITTEN;
		if (last_tok.op != OP_WRITE) begin
			res_data.ttl_out = last_tok.ttl;
			if (last_tok.op == OP_FORWARD && last_tok.ttl <= TTL_LIMIT) begin
				res_verdict = VERDICT_TTL_EXPIRED;
			end else if (!last_tok.hit) begin
				res_verdict = (last_tok.op == OP_FORWARD) ? VERDICT_NO_ROUTE_ICMP :
					VERDICT_NO_ROUTE_DROP;
			end else begin
				res_verdict = VERDICT_FOUND;
				res_data.hop_addr = (last_tok.best_gateway != '0) ? last_tok.best_gateway :
					last_tok.dst_addr;
				res_data.out_iface = last_tok.best_iface;
				if (last_tok.op == OP_FORWARD) begin
					res_data.ttl_out = last_tok.ttl - TTL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
			end else if (last_valid && adv) begin
				busy_q <= 1'b0;
			end
			if (last_valid && adv) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (last_valid && adv) begin
			m_data_q <= res_data;
			verdict_q <= res_verdict;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = m_data_q;
	assign m_axis_tuser = verdict_q;

endmodule

>>> src/irl_checker.sv
// port level checks for the ipv4 route lookup block, bound to the top level
`timescale 1ns / 1ps
module irl_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic [irl_pkg::OP_W-1:0]       s_axis_tuser,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [irl_pkg::M_DATA_W-1:0]   m_axis_tdata,
	input logic [irl_pkg::VERDICT_W-1:0]  m_axis_tuser
);
	import irl_pkg::*;

	// a real operation blocks the input until its result is out
	a_busy_after_op: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_WRITE ||
		s_axis_tuser == OP_FORWARD || s_axis_tuser == OP_SEND)) |=> !s_axis_tready)
		else $error("input ready after operation accepted");

	// a new result only appears at the end of a busy period
	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result without a transaction in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
		(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
		else $error("output transaction changed while stalled");

	a_verdict_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser <= VERDICT_WRITTEN))
		else $error("verdict out of range");

	a_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == VERDICT_WRITTEN) |-> (m_axis_tdata == '0))
		else $error("write result carries data");

endmodule

bind ipv4_route_lookup_lpm_top irl_checker u_irl_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

>>> dv/ipv4_route_lookup_lpm_checker.sv
// checker for the route lookup block: mirrors the route table and compares every decision
`timescale 1ns / 1ps
module ipv4_route_lookup_lpm_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	input  logic                           s_axis_tready,
	input  logic [irl_pkg::S_DATA_W-1:0]   s_axis_tdata,
	input  logic [irl_pkg::OP_W-1:0]       s_axis_tuser,
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	input  logic [irl_pkg::M_DATA_W-1:0]   m_axis_tdata,
	input  logic [irl_pkg::VERDICT_W-1:0]  m_axis_tuser,
	output int                             mismatches,
	output int                             outstanding,
	output int                             decisions_seen,
	output int                             routes_found
);
	import irl_pkg::*;

	typedef struct packed {
		logic [VERDICT_W-1:0] verdict;
		logic [ADDR_W-1:0]    hop_addr;
		logic [IFACE_W-1:0]   out_iface;
		logic [TTL_W-1:0]     ttl_out;
	} decision_t;

	logic               fib_valid   [TABLE_ENTRIES];
	logic [ADDR_W-1:0]  fib_dest    [TABLE_ENTRIES];
	logic [ADDR_W-1:0]  fib_mask    [TABLE_ENTRIES];
	logic [ADDR_W-1:0]  fib_gateway [TABLE_ENTRIES];
	logic [IFACE_W-1:0] fib_iface   [TABLE_ENTRIES];

	decision_t pending_decisions[$];

	task automatic report_mismatch(input string msg);
		if (mismatches < 50) begin
			$display("%0t: mismatch: %s", $time, msg);
		end
		mismatches++;
	endtask

	// updates the mirrored table and returns 1 when the transaction produces a decision
	function automatic logic route_decision(input logic [OP_W-1:0] op, input s_data_t d,
			output decision_t dec);
		logic              hit;
		logic [ADDR_W-1:0] best_mask;
		int                best;
		dec = '0;
		hit = 1'b0;
		best_mask = '0;
		best = 0;
		if (op == OP_WRITE) begin
			if (d.entry_index < TABLE_ENTRIES && d.entry_iface < IFACE_COUNT) begin
				fib_valid[d.entry_index] = d.entry_valid;
				fib_dest[d.entry_index] = d.entry_dest;
				fib_mask[d.entry_index] = d.entry_mask;
				fib_gateway[d.entry_index] = d.entry_gateway;
				fib_iface[d.entry_index] = d.entry_iface;
			end
			dec.verdict = VERDICT_WRITTEN;
			return 1'b1;
		end
		if (op != OP_FORWARD && op != OP_SEND) begin
			return 1'b0;
		end
		dec.ttl_out = d.ttl_in;
		if (op == OP_FORWARD && d.ttl_in <= TTL_LIMIT) begin
			dec.verdict = VERDICT_TTL_EXPIRED;
			return 1'b1;
		end
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (fib_valid[i] && (d.dst_addr & fib_mask[i]) == (fib_dest[i] & fib_mask[i])
					&& (!hit || fib_mask[i] > best_mask)) begin
				hit = 1'b1;
				best = i;
				best_mask = fib_mask[i];
			end
		end
		if (!hit) begin
			dec.verdict = (op == OP_FORWARD) ? VERDICT_NO_ROUTE_ICMP : VERDICT_NO_ROUTE_DROP;
			return 1'b1;
		end
		dec.verdict = VERDICT_FOUND;
		dec.hop_addr = (fib_gateway[best] != '0) ? fib_gateway[best] : d.dst_addr;
		dec.out_iface = fib_iface[best];
		if (op == OP_FORWARD) begin
			dec.ttl_out = d.ttl_in - 1'b1;
		end
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		s_data_t   item;
		m_data_t   res;
		decision_t dec;
		decision_t want;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				fib_valid[i] = 1'b0;
			end
			pending_decisions.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				res = m_axis_tdata;
				decisions_seen++;
				if (pending_decisions.size() == 0) begin
					report_mismatch($sformatf("unexpected transaction, verdict %0d hop %h",
						m_axis_tuser, res.hop_addr));
				end else begin
					want = pending_decisions.pop_front();
					if (m_axis_tuser !== want.verdict) begin
						report_mismatch($sformatf("verdict %0d, expected %0d",
							m_axis_tuser, want.verdict));
					end
					if (res.hop_addr !== want.hop_addr) begin
						report_mismatch($sformatf("hop %h, expected %h",
							res.hop_addr, want.hop_addr));
					end
					if (res.out_iface !== want.out_iface) begin
						report_mismatch($sformatf("out_iface %0d, expected %0d",
							res.out_iface, want.out_iface));
					end
					if (res.ttl_out !== want.ttl_out) begin
						report_mismatch($sformatf("ttl_out %0d, expected %0d",
							res.ttl_out, want.ttl_out));
					end
					if (want.verdict == VERDICT_FOUND) begin
						routes_found++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				item = s_axis_tdata;
				if (route_decision(s_axis_tuser, item, dec)) begin
					pending_decisions.push_back(dec);
				end
			end
		end
		outstanding = pending_decisions.size();
	end

endmodule

>>> dv/ipv4_route_lookup_lpm_top_tb.sv
// testbench top for the route lookup block: stimulus, flow control and verdict
`timescale 1ns / 1ps
module ipv4_route_lookup_lpm_top_tb;
	import irl_pkg::*;

	localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;
	localparam int ITEM_TARGET = 1250;
	localparam int DRAIN_CYCLES = 40;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [S_DATA_W-1:0]  s_axis_tdata;
	logic [OP_W-1:0]      s_axis_tuser;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [M_DATA_W-1:0]  m_axis_tdata;
	logic [VERDICT_W-1:0] m_axis_tuser;

	int mismatches;
	int outstanding;
	int decisions_seen;
	int routes_found;

	bit calm;
	int sent_writes;
	int sent_forwards;
	int sent_sends;
	int sent_ignored;

	// written routes, used to aim packet addresses at the table and to nest new routes on them
	bit                known_used [TABLE_ENTRIES];
	logic [ADDR_W-1:0] known_dest [TABLE_ENTRIES];
	logic [ADDR_W-1:0] known_mask [TABLE_ENTRIES];

	ipv4_route_lookup_lpm_top DUT (
		.clk,
		.arst_n,
		.s_axis_tvalid,
		.s_axis_tready,
		.s_axis_tdata,
		.s_axis_tuser,
		.m_axis_tvalid,
		.m_axis_tready,
		.m_axis_tdata,
		.m_axis_tuser
	);

	ipv4_route_lookup_lpm_checker route_checker (
		.clk,
		.arst_n,
		.s_axis_tvalid,
		.s_axis_tready,
		.s_axis_tdata,
		.s_axis_tuser,
		.m_axis_tvalid,
		.m_axis_tready,
		.m_axis_tdata,
		.m_axis_tuser,
		.mismatches,
		.outstanding,
		.decisions_seen,
		.routes_found
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(4, 40);
	endfunction

	function automatic logic [ADDR_W-1:0] prefix_mask(input int len);
		if (len == 0) begin
			return '0;
		end
		return 32'hFFFF_FFFF << (32 - len);
	endfunction

	function automatic logic [ADDR_W-1:0] aim_address();
		int                slot;
		logic [ADDR_W-1:0] a;
		slot = $urandom_range(0, TABLE_ENTRIES - 1);
		if (!known_used[slot] || $urandom_range(0, 9) == 0) begin
			return $urandom;
		end
		a = (known_dest[slot] & known_mask[slot]) | ($urandom & ~known_mask[slot]);
		if ($urandom_range(0, 7) == 0) begin
			a[$urandom_range(0, ADDR_W - 1)] ^= 1'b1;
		end
		return a;
	endfunction

	task automatic push_item(input logic [OP_W-1:0] op, input s_data_t d);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		s_axis_tuser <= op;
		do @(posedge clk); while (!s_axis_tready);
		case (op)
			OP_WRITE: sent_writes++;
			OP_FORWARD: sent_forwards++;
			OP_SEND: sent_sends++;
			default: sent_ignored++;
		endcase
		gap = calm ? 0 : idle_len();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_route(input logic [IDX_W-1:0] idx, input logic valid,
			input logic [ADDR_W-1:0] dest, input logic [ADDR_W-1:0] mask,
			input logic [ADDR_W-1:0] gw, input logic [IFACE_W-1:0] iface);
		s_data_t d;
		d.pad = '0;
		d.ttl_in = TTL_W'($urandom);
		d.dst_addr = $urandom;
		d.entry_iface = iface;
		d.entry_gateway = gw;
		d.entry_mask = mask;
		d.entry_dest = dest;
		d.entry_valid = valid;
		d.entry_index = idx;
		known_used[idx] = valid;
		known_dest[idx] = dest;
		known_mask[idx] = mask;
		push_item(OP_WRITE, d);
	endtask

	task automatic route_packet(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
			input logic [TTL_W-1:0] ttl);
		s_data_t d;
		d.pad = '0;
		d.ttl_in = ttl;
		d.dst_addr = addr;
		d.entry_iface = IFACE_W'($urandom);
		d.entry_gateway = $urandom;
		d.entry_mask = $urandom;
		d.entry_dest = $urandom;
		d.entry_valid = 1'($urandom);
		d.entry_index = IDX_W'($urandom);
		push_item(op, d);
	endtask

	task automatic push_ignored();
		s_data_t d;
		d.pad = '0;
		d.ttl_in = TTL_W'($urandom);
		d.dst_addr = $urandom;
		d.entry_iface = IFACE_W'($urandom);
		d.entry_gateway = $urandom;
		d.entry_mask = $urandom;
		d.entry_dest = $urandom;
		d.entry_valid = 1'($urandom);
		d.entry_index = IDX_W'($urandom);
		push_item(OP_IGNORED, d);
	endtask

	task automatic random_route();
		int                slot;
		int                peer;
		int                kind;
		logic [ADDR_W-1:0] dest;
		logic [ADDR_W-1:0] mask;
		logic [ADDR_W-1:0] gw;
		slot = $urandom_range(0, TABLE_ENTRIES - 1);
		peer = $urandom_range(0, TABLE_ENTRIES - 1);
		kind = $urandom_range(0, 9);
		dest = $urandom;
		mask = prefix_mask($urandom_range(0, 32));
		gw = ($urandom_range(0, 4) < 2) ? '0 : $urandom;
		// nest under or over an existing route
		if (known_used[peer] && kind < 4) begin
			dest = known_dest[peer];
		end
		case (kind)
			6: begin
				// equal mask tie with an existing route
				if (known_used[peer]) begin
					dest = known_dest[peer] ^ ($urandom & ~known_mask[peer]);
					mask = known_mask[peer];
				end
			end
			7: mask = $urandom;
			8: mask = '1;
			default: ;
		endcase
		write_route(IDX_W'(slot), kind != 9, dest, mask, gw,
			IFACE_W'($urandom_range(0, 15)));
	endtask

	task automatic random_packet();
		logic [OP_W-1:0]  op;
		logic [TTL_W-1:0] ttl;
		int               r;
		op = $urandom_range(0, 1) ? OP_FORWARD : OP_SEND;
		r = $urandom_range(0, 19);
		ttl = (r < 3) ? TTL_W'(r) : TTL_W'($urandom);
		route_packet(op, aim_address(), ttl);
	endtask

	initial begin
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			int hold;
			@(posedge clk);
			if (hold > 0) begin
				hold--;
			end else if (calm || $urandom_range(0, 3) != 0) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b0;
				hold = idle_len();
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = OP_WRITE;
		calm = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// empty table, ttl boundaries
		route_packet(OP_FORWARD, 32'h0A01_0203, 8'd255);
		route_packet(OP_SEND, 32'h0000_0000, 8'd0);
		route_packet(OP_FORWARD, 32'hFFFF_FFFF, 8'd0);
		route_packet(OP_FORWARD, 32'h0A01_0203, 8'd1);
		// default route, host route, nested prefixes, equal mask tie, odd mask
		write_route(4'd0, 1'b1, 32'h0000_0000, 32'h0000_0000, 32'hC0A8_0001, 4'd15);
		write_route(4'd15, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 4'd0);
		write_route(4'd3, 1'b1, 32'h0A00_0000, 32'hFF00_0000, 32'h0000_0000, 4'd5);
		write_route(4'd4, 1'b1, 32'h0A01_0000, 32'hFFFF_0000, 32'hFFFF_FFFF, 4'd9);
		write_route(4'd7, 1'b1, 32'h0A01_FFFF, 32'hFFFF_0000, 32'h0A00_00FE, 4'd2);
		write_route(4'd9, 1'b1, 32'h0000_1234, 32'h0000_FFFF, 32'h0A00_00FD, 4'd12);
		route_packet(OP_FORWARD, 32'h0A01_0203, 8'd2);
		route_packet(OP_FORWARD, 32'h0A02_0304, 8'd255);
		route_packet(OP_SEND, 32'hFFFF_FFFF, 8'd0);
		route_packet(OP_SEND, 32'h0102_0304, 8'd1);
		route_packet(OP_FORWARD, 32'h0B00_1234, 8'd255);
		route_packet(OP_FORWARD, 32'h0A02_1234, 8'd8);
		route_packet(OP_FORWARD, 32'h0A01_0203, 8'd1);
		push_ignored();
		// removing the tie winner hands the match to the next slot
		write_route(4'd4, 1'b0, 32'h0A01_0000, 32'hFFFF_0000, 32'hFFFF_FFFF, 4'd9);
		route_packet(OP_FORWARD, 32'h0A01_0203, 8'd64);
		write_route(4'd0, 1'b0, 32'h0000_0000, 32'h0000_0000, 32'hC0A8_0001, 4'd15);
		route_packet(OP_SEND, 32'h0102_0304, 8'd200);
		route_packet(OP_FORWARD, 32'h0102_0304, 8'd200);
		push_ignored();

		while (sent_writes + sent_forwards + sent_sends < ITEM_TARGET) begin
			calm = ($urandom_range(0, 4) == 0);
			repeat ($urandom_range(1, 6)) random_route();
			repeat ($urandom_range(4, 20)) begin
				if ($urandom_range(0, 19) == 0) begin
					push_ignored();
				end
				if ($urandom_range(0, 24) == 0) begin
					random_route();
				end
				random_packet();
			end
		end

		calm = 1'b1;
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d route writes, %0d forwards, %0d sends, %0d ignored operations",
			sent_writes, sent_forwards, sent_sends, sent_ignored);
		$display("%0d decisions checked, %0d of them resolved a next hop",
			decisions_seen, routes_found);
		if (mismatches == 0) begin
			$display("** ipv4_route_lookup_lpm_top: PASSED **");
		end else begin
			$display("** ipv4_route_lookup_lpm_top: FAILED **");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("timeout with %0d decisions outstanding", outstanding);
		$display("** ipv4_route_lookup_lpm_top: FAILED **");
		$finish;
	end

endmodule
